>>> rtl/kwhm_pkg.sv
// kwhm_pkg: shared types and constants for the k-way heap merge block
// request and result structs, status codes and controller states
// no dependencies
`default_nettype none

package kwhm_pkg;

	// fixed field widths
	localparam int VALUE_W    = 32;
	localparam int LIST_IDX_W = 4;
	localparam int CFG_W      = 5;

	// active list count after reset
	localparam logic [CFG_W-1:0] ACTIVE_RESET = 5'd16;

	typedef enum logic {
		KIND_APPEND = 1'b0,
		KIND_POP    = 1'b1
	} op_kind_t;

	typedef enum logic [1:0] {
		ST_OK        = 2'd0,
		ST_FULL      = 2'd1,
		ST_EMPTY     = 2'd2,
		ST_BAD_INDEX = 2'd3
	} status_t;

	typedef struct packed {
		op_kind_t                     kind;
		logic [LIST_IDX_W-1:0]        list_index;
		logic signed [VALUE_W-1:0]    value;
	} op_t;

	typedef struct packed {
		status_t                      status;
		logic signed [VALUE_W-1:0]    merged_value;
		logic [LIST_IDX_W-1:0]        source_list;
	} res_t;

	typedef enum logic [2:0] {
		S_IDLE   = 3'd0,
		S_APPEND = 3'd1,
		S_SCAN   = 3'd2,
		S_LAST   = 3'd3,
		S_POP    = 3'd4,
		S_DONE   = 3'd5
	} state_t;

endpackage

`default_nettype wire

>>> rtl/k_way_heap_merge.sv
// k_way_heap_merge: k-way merge of sorted lists, built on kwhm_pkg and kwhm_ram
// append requests are checked and written in the append state; pop requests scan the heads
// of the n active lists and then take the smallest head in the pop state,
// n being the effective active list count (1..NUM_LISTS): the list heads are read one
// per cycle through the single read port of the list store. A new request is taken only in idle.
// reset clears counts, head pointers, control state and sets 16 active lists; no store clear
`default_nettype none

module k_way_heap_merge #(
	parameter int NUM_LISTS  = 16,
	parameter int LIST_DEPTH = 64
) (
	input  wire logic               clk,
	input  wire logic               arst_n,
	// request channel
	input  wire logic               op_valid,
	output logic                    op_stall,
	input  wire kwhm_pkg::op_t      op,
	// result channel
	output logic                    res_valid,
	input  wire logic               res_stall,
	output kwhm_pkg::res_t          res,
	// configuration write channel
	input  wire logic               cfg_valid,
	output logic                    cfg_ready,
	input  wire logic [4:0]         cfg_data
);

	import kwhm_pkg::*;

	localparam int LW   = $clog2(NUM_LISTS);
	localparam int HPW  = $clog2(LIST_DEPTH);
	localparam int CNTW = $clog2(LIST_DEPTH + 1);
	localparam int SW   = CNTW + 1;
	localparam int IW   = (LW + 1 > 6) ? LW + 1 : 6;
	localparam int AW   = LW + HPW;
	localparam int RAM_DEPTH = 2 ** AW;

	state_t                     state_q, state_d;
	logic [CFG_W-1:0]           act_q;
	op_t                        op_q;

	logic [HPW-1:0]             head_q [NUM_LISTS];
	logic [CNTW-1:0]            cnt_q  [NUM_LISTS];

	logic [IW-1:0]              scan_q;
	logic                       cmp_v_s1;
	logic [IW-1:0]              cmp_idx_s1;
	logic                       found_q;
	logic signed [VALUE_W-1:0]  best_val_q;
	logic [IW-1:0]              best_idx_q;

	res_t                       res_q, pend_q, fin_res;
	logic                       res_valid_q;

	logic [IW-1:0]              act_w, eff_w, last_w, li_w;
	logic [LW-1:0]              ctl_addr;
	logic [HPW-1:0]             ctl_head, head_next, slot;
	logic [CNTW-1:0]            ctl_cnt;
	logic [SW-1:0]              tail_sum;
	logic [HPW:0]               head_inc;
	logic                       fin, app_ok, pop_upd, out_free, load_res;
	logic                       accept, bad_idx, full;
	logic signed [VALUE_W-1:0]  ram_rdata;

	// handshakes
	assign accept    = op_valid && !op_stall;
	assign op_stall  = (state_q != S_IDLE);
	assign cfg_ready = (state_q == S_IDLE);
	assign out_free  = !res_valid_q || !res_stall;

	// effective list count: zero acts as one, clipped to the list count
	assign act_w = IW'(act_q);
	always_comb begin
		priority if (act_w == '0) begin
			eff_w = IW'(1);
		end else if (act_w > IW'(NUM_LISTS)) begin
			eff_w = IW'(NUM_LISTS);
		end else begin
			eff_w = act_w;
		end
	end
	assign last_w = eff_w - IW'(1);
	assign li_w   = IW'(op_q.list_index);

	// per-list control read at one address
	assign ctl_head = head_q[ctl_addr];
	assign ctl_cnt  = cnt_q[ctl_addr];
	assign bad_idx  = (li_w >= eff_w);
	assign full     = (ctl_cnt >= CNTW'(LIST_DEPTH));

	// tail slot, wrapped around the circular list
	always_comb begin
		tail_sum = SW'(ctl_head) + SW'(ctl_cnt);
		if (tail_sum >= SW'(LIST_DEPTH)) begin
			tail_sum = tail_sum - SW'(LIST_DEPTH);
		end
		slot = tail_sum[HPW-1:0];
	end

	// head pointer advance
	always_comb begin
		head_inc = (HPW + 1)'(ctl_head) + (HPW + 1)'(1);
		if (head_inc == (HPW + 1)'(LIST_DEPTH)) begin
			head_next = '0;
		end else begin
			head_next = head_inc[HPW-1:0];
		end
	end

	// state register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= S_IDLE;
		end else begin
			state_q <= state_d;
		end
	end

	// next state and controls
	always_comb begin
		state_d  = state_q;
		ctl_addr = '0;
		fin      = 1'b0;
		fin_res  = '0;
		app_ok   = 1'b0;
		pop_upd  = 1'b0;
		unique case (state_q)
			S_IDLE: begin
				if (op_valid) begin
					state_d = (op.kind == KIND_POP) ? S_SCAN : S_APPEND;
				end
			end
			S_APPEND: begin
				ctl_addr = li_w[LW-1:0];
				fin      = 1'b1;
				priority if (bad_idx) begin
					fin_res.status = ST_BAD_INDEX;
				end else if (full) begin
					fin_res.status = ST_FULL;
				end else begin
					fin_res.status = ST_OK;
					app_ok         = 1'b1;
				end
				state_d = out_free ? S_IDLE : S_DONE;
			end
			S_SCAN: begin
				ctl_addr = scan_q[LW-1:0];
				if (scan_q == last_w) begin
					state_d = S_LAST;
				end
			end
			S_LAST: begin
				state_d = S_POP;
			end
			S_POP: begin
				ctl_addr = best_idx_q[LW-1:0];
				fin      = 1'b1;
				if (found_q) begin
					pop_upd              = 1'b1;
					fin_res.status       = ST_OK;
					fin_res.merged_value = best_val_q;
					fin_res.source_list  = best_idx_q[LIST_IDX_W-1:0];
				end else begin
					fin_res.status = ST_EMPTY;
				end
				state_d = out_free ? S_IDLE : S_DONE;
			end
			S_DONE: begin
				if (out_free) begin
					state_d = S_IDLE;
				end
			end
			default: begin
				state_d = S_IDLE;
			end
		endcase
	end

	// configuration register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			act_q <= ACTIVE_RESET;
		end else if (cfg_valid && cfg_ready) begin
			act_q <= cfg_data;
		end
	end

	// request capture
	always_ff @(posedge clk) begin
		if (accept) begin
			op_q <= op;
		end
	end

	// list counts and head pointers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			for (int i = 0; i < NUM_LISTS; i++) begin
				head_q[i] <= '0;
				cnt_q[i]  <= '0;
			end
		end else if (app_ok) begin
			cnt_q[ctl_addr] <= ctl_cnt + CNTW'(1);
		end else if (pop_upd) begin
			head_q[ctl_addr] <= head_next;
			cnt_q[ctl_addr]  <= ctl_cnt - CNTW'(1);
		end
	end

	// list store: heads read during the scan, appends written at the tail;
	// one request at a time, so the scan never reads an entry while an append writes it
	kwhm_ram #(
		.WIDTH (VALUE_W),
		.DEPTH (RAM_DEPTH)
	) u_store (
		.clk   (clk),
		.we    (app_ok),
		.waddr ({ctl_addr, slot}),
		.wdata (op_q.value),
		.raddr ({ctl_addr, ctl_head}),
		.rdata (ram_rdata)
	);

	// scan control
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			scan_q   <= '0;
			cmp_v_s1 <= 1'b0;
			found_q  <= 1'b0;
		end else begin
			cmp_v_s1 <= (state_q == S_SCAN) && (ctl_cnt != '0);
			if (accept) begin
				scan_q  <= '0;
				found_q <= 1'b0;
			end else begin
				if (state_q == S_SCAN) begin
					scan_q <= scan_q + IW'(1);
				end
				if (cmp_v_s1) begin
					found_q <= 1'b1;
				end
			end
		end
	end

	// running minimum; a strict compare keeps the lowest list on ties
	always_ff @(posedge clk) begin
		cmp_idx_s1 <= scan_q;
		if (cmp_v_s1 && (!found_q || ram_rdata < best_val_q)) begin
			best_val_q <= ram_rdata;
			best_idx_q <= cmp_idx_s1;
		end
	end

	// output register with a pending slot behind it
	assign load_res = (fin || state_q == S_DONE) && out_free;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			res_valid_q <= 1'b0;
		end else if (load_res) begin
			res_valid_q <= 1'b1;
		end else if (!res_stall) begin
			res_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (load_res) begin
			res_q <= (state_q == S_DONE) ? pend_q : fin_res;
		end
		if (fin && !out_free) begin
			pend_q <= fin_res;
		end
	end

	assign res_valid = res_valid_q;
	assign res       = res_q;

`ifndef NO_ASSERTIONS
	a_scan_bound: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_SCAN) |-> (scan_q <= last_w))
		else $error("scan index ran past the last active list");

	a_write_append: assert property (@(posedge clk) disable iff (!arst_n)
		app_ok |-> (state_q == S_APPEND && !bad_idx && !full))
		else $error("list store written outside a valid append");

	a_pop_nonempty: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_POP && found_q) |-> (ctl_cnt != '0))
		else $error("pop selected an empty list");

	a_append_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == S_APPEND) |=> (state_q == S_IDLE || state_q == S_DONE))
		else $error("append did not finish in one cycle");
`endif

endmodule

`default_nettype wire

>>> rtl/kwhm_ram.sv
// kwhm_ram: generic simple dual-port ram, one write and one registered read port
// depends on nothing
`default_nettype none

module kwhm_ram #(
	parameter int WIDTH = 32,
	parameter int DEPTH = 1024
) (
	input  wire logic                     clk,
	input  wire logic                     we,
	input  wire logic [$clog2(DEPTH)-1:0] waddr,
	input  wire logic [WIDTH-1:0]         wdata,
	input  wire logic [$clog2(DEPTH)-1:0] raddr,
	output logic      [WIDTH-1:0]         rdata
);

	logic [WIDTH-1:0] mem [DEPTH];
	logic [WIDTH-1:0] rdata_q;

	// write port
	always_ff @(posedge clk) begin
		if (we) begin
			mem[waddr] <= wdata;
		end
	end

	// registered read port
	always_ff @(posedge clk) begin
		rdata_q <= mem[raddr];
	end

	assign rdata = rdata_q;

endmodule

`default_nettype wire
